// ===== rtl/core/imu_bsw_pkg.sv =====
package imu_bsw_pkg;

   localparam int unsigned DIVIDEND_W = 64;
   localparam int unsigned DIVISOR_W  = 32;
   localparam int unsigned RAD_W      = 64;
   localparam int unsigned ROOT_W     = 32;
   localparam int unsigned VAL_W      = 32;
   localparam int unsigned CERT_W     = 17;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [CERT_W-1:0] Q_ONE         = 17'h10000;
   localparam logic [VAL_W-1:0]  THRESH_RESET  = 32'd65536;
   localparam logic [VAL_W-1:0]  GRAVITY_RESET = 32'd642690;
   localparam logic [VAL_W-1:0]  GAIN_RESET    = 32'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STILL_THRESHOLD   = 1'b0,
      CSR_GRAVITY_MAGNITUDE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [VAL_W-1:0]  x;
      logic [VAL_W-1:0]  y;
      logic [VAL_W-1:0]  z;
      logic [CERT_W-1:0] w;
   } gyro_entry_type;

   typedef struct packed {
      logic [VAL_W-1:0]  value;
      logic [CERT_W-1:0] w;
   } gain_entry_type;

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_NDIV    = 14'b00000000000010,
      ST_GWR     = 14'b00000000000100,
      ST_GACC    = 14'b00000000001000,
      ST_BDIV    = 14'b00000000010000,
      ST_SCL_MUL = 14'b00000000100000,
      ST_SCL_SQ  = 14'b00000001000000,
      ST_SCL_ADD = 14'b00000010000000,
      ST_SQRT    = 14'b00000100000000,
      ST_VDIV    = 14'b00001000000000,
      ST_KWR     = 14'b00010000000000,
      ST_KACC    = 14'b00100000000000,
      ST_KDIV    = 14'b01000000000000,
      ST_DONE    = 14'b10000000000000
   } state_type;

endpackage

// ===== rtl/core/imu_bsw_div.sv =====
module imu_bsw_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [imu_bsw_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [imu_bsw_pkg::DIVISOR_W-1:0]  divisor,
   output logic                              busy,
   output logic                              done,
   output logic [imu_bsw_pkg::DIVIDEND_W-1:0] quotient
);
   import imu_bsw_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  den_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
            rem_ff  <= '0;
            den_ff  <= divisor;
            quo_ff  <= dividend;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_ff <= {quo_ff[DIVIDEND_W-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/imu_bsw_sqrt.sv =====
module imu_bsw_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [imu_bsw_pkg::RAD_W-1:0]  radicand,
   output logic                          done,
   output logic [imu_bsw_pkg::ROOT_W-1:0] root
);
   import imu_bsw_pkg::*;

   localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W:0]   rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W+2:0] shifted;
   logic [ROOT_W+2:0] trial;
   logic              ge;

   // two radicand bits per step, one root bit out
   assign shifted = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign ge      = shifted >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            rem_ff  <= ge ? (ROOT_W+1)'(shifted - trial) : shifted[ROOT_W:0];
            root_ff <= {root_ff[ROOT_W-2:0], ge};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/core/imu_bias_scale_weighted_window_core.sv =====
// IMU gyro bias and accelerometer gain estimator, one request per still-camera event.
// Requests arrive on req_* (valid/ready); each gives exactly one response on rsp_*
// (valid/ready) carrying the weighted gyro bias, the accelerometer gain and a flag
// set when the gain was recomputed. csr_* writes the threshold (index 0) and the
// gravity magnitude (index 1); write only while no request is in flight.
// The window entries live in two small synchronous memories that are written once
// and then swept, one entry per cycle, to form the weighted sums.
// The arithmetic runs on the shared 64-step divider and the 32-step square root:
// a normalisation division (skipped on a zero threshold), a sweep of the gyro window,
// a division per bias axis when the gyro weight sum is non-zero, and on a repeat event
// scaling, the root, a division for the gain value, a sweep of the gain window and,
// when its weight sum is non-zero, a division for the gain average.
// One request is processed at a time; req_ready is high only while idle. A finished
// response sits in the output register, so the next request is taken while the
// receiver stalls; the block only waits at its last step if the previous
// response has not yet been taken.
// Reset is synchronous; it clears the fill counts, previous readings and held bias
// and sets the gain to one. No clearing pass is needed.
module imu_bias_scale_weighted_window_core #(
   parameter int unsigned WINDOW_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [imu_bsw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [imu_bsw_pkg::VAL_W-1:0]       csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [31:0]                         req_pixel_change,
   input  logic                                req_repeat_event,
   input  logic signed [31:0]                  req_gyro_x,
   input  logic signed [31:0]                  req_gyro_y,
   input  logic signed [31:0]                  req_gyro_z,
   input  logic signed [31:0]                  req_accel_x,
   input  logic signed [31:0]                  req_accel_y,
   input  logic signed [31:0]                  req_accel_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [31:0]                  rsp_bias_x,
   output logic signed [31:0]                  rsp_bias_y,
   output logic signed [31:0]                  rsp_bias_z,
   output logic [31:0]                         rsp_accel_gain,
   output logic                                rsp_gain_updated
);
   import imu_bsw_pkg::*;

   localparam int unsigned PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned WSUM_W = CERT_W + FILL_W;
   localparam int unsigned PROD_W = VAL_W + CERT_W + 1;
   localparam int unsigned NUM_W  = PROD_W - 1 + FILL_W;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

   function automatic logic [VAL_W-1:0] abs32(input logic [VAL_W-1:0] a);
      abs32 = a[VAL_W-1] ? (~a + 1'b1) : a;
   endfunction

   state_type state_ff;

   logic [VAL_W-1:0] thresh_ff;
   logic [VAL_W-1:0] gravity_ff;

   // captured request
   logic [VAL_W-1:0] cap_gx_ff, cap_gy_ff, cap_gz_ff;
   logic [VAL_W-1:0] cap_ax_ff, cap_ay_ff, cap_az_ff;
   logic             cap_rep_ff;

   // long-lived state
   logic [VAL_W-1:0]  prev_ax_ff, prev_ay_ff, prev_az_ff;
   logic [CERT_W-1:0] prev_norm_ff;
   logic [VAL_W-1:0]  gain_now_ff;
   logic [VAL_W-1:0]  bias_x_ff, bias_y_ff, bias_z_ff;
   logic [FILL_W-1:0] gyro_fill_ff, gain_fill_ff;
   logic [PTR_W-1:0]  gyro_ptr_ff, gain_ptr_ff;

   gyro_entry_type gyro_mem [WINDOW_DEPTH];
   gain_entry_type gain_mem [WINDOW_DEPTH];
   gyro_entry_type gyro_rd_ff;
   gain_entry_type gain_rd_ff;

   // per-request working values
   logic [CERT_W-1:0]     norm_ff;
   logic [1:0]            axis_ff;
   logic                  neg_ff;
   logic [DIVIDEND_W-1:0] mul_ff;
   logic [61:0]           sq_ff;
   logic [RAD_W-1:0]      sumsq_ff;
   logic [VAL_W-1:0]      val_ff;
   logic                  updated_ff;

   // window sweep
   logic [FILL_W-1:0]        rd_cnt_ff;
   logic                     rd_v1_ff, rd_v2_ff;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic [PROD_W-2:0]        prod_g_ff;
   logic [CERT_W-1:0]        w_p_ff;
   logic signed [NUM_W-1:0]  acc_x_ff, acc_y_ff, acc_z_ff;
   logic [NUM_W-1:0]         acc_g_ff;
   logic [WSUM_W-1:0]        acc_w_ff;

   // response register
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] rsp_bx_ff, rsp_by_ff, rsp_bz_ff, rsp_gain_ff;
   logic             rsp_upd_ff;

   // shared divider and square root unit
   logic                  div_start_ff;
   logic [DIVIDEND_W-1:0] div_num_ff;
   logic [DIVISOR_W-1:0]  div_den_ff;
   logic                  div_busy, div_done;
   logic [DIVIDEND_W-1:0] div_q;
   logic                  sqrt_start_ff;
   logic                  sqrt_done;
   logic [ROOT_W-1:0]     sqrt_root;

   logic                  req_fire;
   logic                  sweeping;
   logic [FILL_W-1:0]     fill_sel;
   logic                  rd_issue;
   logic                  sweep_done;
   logic [CERT_W:0]       norm_sum;
   logic [CERT_W-1:0]     norm_avg;
   logic signed [NUM_W-1:0] acc_sel;
   logic [NUM_W-1:0]      acc_mag;
   logic [VAL_W-1:0]      prev_a_sel;
   logic [47:0]           scaled_full;
   logic [30:0]           scaled;
   logic [RAD_W-1:0]      sumsq_next;
   logic [CERT_W-1:0]     norm_q;

   imu_bsw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   imu_bsw_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand (sumsq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign sweeping   = (state_ff == ST_GACC) || (state_ff == ST_KACC);
   assign fill_sel   = (state_ff == ST_GACC) ? gyro_fill_ff : gain_fill_ff;
   assign rd_issue   = sweeping && (rd_cnt_ff != fill_sel);
   assign sweep_done = (rd_cnt_ff == fill_sel) && !rd_v1_ff && !rd_v2_ff;

   assign norm_sum = {1'b0, norm_ff} + {1'b0, prev_norm_ff};
   assign norm_avg = norm_sum[CERT_W:1];

   always_comb begin
      case (axis_ff)
         2'd0:    acc_sel = acc_x_ff;
         2'd1:    acc_sel = acc_y_ff;
         default: acc_sel = acc_z_ff;
      endcase
   end
   assign acc_mag = acc_sel[NUM_W-1] ? NUM_W'(-acc_sel) : NUM_W'(acc_sel);

   always_comb begin
      case (axis_ff)
         2'd0:    prev_a_sel = prev_ax_ff;
         2'd1:    prev_a_sel = prev_ay_ff;
         default: prev_a_sel = prev_az_ff;
      endcase
   end

   // saturate the scaled component at 0x7fffffff
   assign scaled_full = mul_ff[63:16];
   assign scaled      = (|scaled_full[47:31]) ? 31'h7FFFFFFF : scaled_full[30:0];
   assign sumsq_next  = sumsq_ff + RAD_W'(sq_ff);

   assign norm_q = ((|div_q[DIVIDEND_W-1:CERT_W]) || (div_q[CERT_W-1:0] > Q_ONE))
                   ? Q_ONE : div_q[CERT_W-1:0];

   // window memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (state_ff == ST_GWR) begin
         gyro_mem[gyro_ptr_ff] <= '{x: cap_gx_ff, y: cap_gy_ff, z: cap_gz_ff,
                                    w: Q_ONE - norm_ff};
      end
      if (state_ff == ST_KWR) begin
         gain_mem[gain_ptr_ff] <= '{value: val_ff, w: Q_ONE - norm_avg};
      end
      if (rd_issue) begin
         gyro_rd_ff <= gyro_mem[rd_cnt_ff[PTR_W-1:0]];
         gain_rd_ff <= gain_mem[rd_cnt_ff[PTR_W-1:0]];
      end
   end

   // sweep products, registered before accumulation
   always_ff @(posedge clock) begin
      if (rd_v1_ff) begin
         prod_x_ff <= $signed(gyro_rd_ff.x) * $signed({1'b0, gyro_rd_ff.w});
         prod_y_ff <= $signed(gyro_rd_ff.y) * $signed({1'b0, gyro_rd_ff.w});
         prod_z_ff <= $signed(gyro_rd_ff.z) * $signed({1'b0, gyro_rd_ff.w});
         prod_g_ff <= gain_rd_ff.value * gain_rd_ff.w;
         w_p_ff    <= (state_ff == ST_GACC) ? gyro_rd_ff.w : gain_rd_ff.w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         thresh_ff     <= THRESH_RESET;
         gravity_ff    <= GRAVITY_RESET;
         prev_ax_ff    <= '0;
         prev_ay_ff    <= '0;
         prev_az_ff    <= '0;
         prev_norm_ff  <= '0;
         gain_now_ff   <= GAIN_RESET;
         bias_x_ff     <= '0;
         bias_y_ff     <= '0;
         bias_z_ff     <= '0;
         gyro_fill_ff  <= '0;
         gain_fill_ff  <= '0;
         gyro_ptr_ff   <= '0;
         gain_ptr_ff   <= '0;
         rd_v1_ff      <= 1'b0;
         rd_v2_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         updated_ff    <= 1'b0;
      end else begin
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         rd_v1_ff      <= rd_issue;
         rd_v2_ff      <= rd_v1_ff;

         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_STILL_THRESHOLD:   thresh_ff  <= csr_wdata;
               CSR_GRAVITY_MAGNITUDE: gravity_ff <= csr_wdata;
               default: ;
            endcase
         end

         // the done step reloads the register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         if (rd_issue) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
         if (rd_v2_ff) begin
            acc_w_ff <= acc_w_ff + WSUM_W'(w_p_ff);
            acc_x_ff <= acc_x_ff + NUM_W'(prod_x_ff);
            acc_y_ff <= acc_y_ff + NUM_W'(prod_y_ff);
            acc_z_ff <= acc_z_ff + NUM_W'(prod_z_ff);
            acc_g_ff <= acc_g_ff + NUM_W'(prod_g_ff);
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  cap_gx_ff  <= req_gyro_x;
                  cap_gy_ff  <= req_gyro_y;
                  cap_gz_ff  <= req_gyro_z;
                  cap_ax_ff  <= req_accel_x;
                  cap_ay_ff  <= req_accel_y;
                  cap_az_ff  <= req_accel_z;
                  cap_rep_ff <= req_repeat_event;
                  updated_ff <= 1'b0;
                  if (thresh_ff == '0) begin
                     norm_ff  <= Q_ONE;
                     state_ff <= ST_GWR;
                  end else begin
                     div_start_ff <= 1'b1;
                     div_num_ff   <= {16'd0, req_pixel_change, 16'd0};
                     div_den_ff   <= thresh_ff;
                     state_ff     <= ST_NDIV;
                  end
               end
            end
            ST_NDIV: begin
               if (div_done) begin
                  norm_ff  <= norm_q;
                  state_ff <= ST_GWR;
               end
            end
            ST_GWR: begin
               gyro_ptr_ff <= (gyro_ptr_ff == PTR_LAST) ? '0 : gyro_ptr_ff + 1'b1;
               if (gyro_fill_ff != FILL_MAX) begin
                  gyro_fill_ff <= gyro_fill_ff + 1'b1;
               end
               rd_cnt_ff <= '0;
               acc_w_ff  <= '0;
               acc_x_ff  <= '0;
               acc_y_ff  <= '0;
               acc_z_ff  <= '0;
               state_ff  <= ST_GACC;
            end
            ST_GACC: begin
               if (sweep_done) begin
                  axis_ff  <= 2'd0;
                  sumsq_ff <= '0;
                  if (acc_w_ff != '0) begin
                     div_start_ff <= 1'b1;
                     div_num_ff   <= DIVIDEND_W'(acc_x_ff[NUM_W-1] ? NUM_W'(-acc_x_ff)
                                                                   : NUM_W'(acc_x_ff));
                     div_den_ff   <= DIVISOR_W'(acc_w_ff);
                     neg_ff       <= acc_x_ff[NUM_W-1];
                     state_ff     <= ST_BDIV;
                  end else begin
                     state_ff <= cap_rep_ff ? ST_SCL_MUL : ST_DONE;
                  end
               end
            end
            ST_BDIV: begin
               if (div_done) begin
                  case (axis_ff)
                     2'd0:    bias_x_ff <= neg_ff ? -div_q[VAL_W-1:0] : div_q[VAL_W-1:0];
                     2'd1:    bias_y_ff <= neg_ff ? -div_q[VAL_W-1:0] : div_q[VAL_W-1:0];
                     default: bias_z_ff <= neg_ff ? -div_q[VAL_W-1:0] : div_q[VAL_W-1:0];
                  endcase
                  if (axis_ff == 2'd2) begin
                     axis_ff  <= 2'd0;
                     state_ff <= cap_rep_ff ? ST_SCL_MUL : ST_DONE;
                  end else begin
                     axis_ff  <= axis_ff + 1'b1;
                     state_ff <= ST_BDIV;
                  end
               end else if (!div_busy && !div_start_ff) begin
                  // launch the next axis once the unit is free
                  div_start_ff <= 1'b1;
                  div_num_ff   <= DIVIDEND_W'(acc_mag);
                  neg_ff       <= acc_sel[NUM_W-1];
               end
            end
            ST_SCL_MUL: begin
               mul_ff   <= abs32(prev_a_sel) * gain_now_ff;
               state_ff <= ST_SCL_SQ;
            end
            ST_SCL_SQ: begin
               sq_ff    <= scaled * scaled;
               state_ff <= ST_SCL_ADD;
            end
            ST_SCL_ADD: begin
               sumsq_ff <= sumsq_next;
               if (axis_ff == 2'd2) begin
                  sqrt_start_ff <= 1'b1;
                  state_ff      <= ST_SQRT;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= ST_SCL_MUL;
               end
            end
            ST_SQRT: begin
               if (sqrt_done) begin
                  if (sqrt_root == '0) begin
                     state_ff <= ST_DONE;
                  end else begin
                     div_start_ff <= 1'b1;
                     div_num_ff   <= {16'd0, gravity_ff, 16'd0};
                     div_den_ff   <= sqrt_root;
                     state_ff     <= ST_VDIV;
                  end
               end
            end
            ST_VDIV: begin
               if (div_done) begin
                  val_ff   <= (|div_q[DIVIDEND_W-1:VAL_W]) ? '1 : div_q[VAL_W-1:0];
                  state_ff <= ST_KWR;
               end
            end
            ST_KWR: begin
               gain_ptr_ff <= (gain_ptr_ff == PTR_LAST) ? '0 : gain_ptr_ff + 1'b1;
               if (gain_fill_ff != FILL_MAX) begin
                  gain_fill_ff <= gain_fill_ff + 1'b1;
               end
               rd_cnt_ff <= '0;
               acc_w_ff  <= '0;
               acc_g_ff  <= '0;
               state_ff  <= ST_KACC;
            end
            ST_KACC: begin
               if (sweep_done) begin
                  if (acc_w_ff != '0) begin
                     div_start_ff <= 1'b1;
                     div_num_ff   <= DIVIDEND_W'(acc_g_ff);
                     div_den_ff   <= DIVISOR_W'(acc_w_ff);
                     state_ff     <= ST_KDIV;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_KDIV: begin
               if (div_done) begin
                  gain_now_ff <= div_q[VAL_W-1:0];
                  updated_ff  <= 1'b1;
                  state_ff    <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_bx_ff    <= bias_x_ff;
                  rsp_by_ff    <= bias_y_ff;
                  rsp_bz_ff    <= bias_z_ff;
                  rsp_gain_ff  <= gain_now_ff;
                  rsp_upd_ff   <= updated_ff;
                  prev_ax_ff   <= cap_ax_ff;
                  prev_ay_ff   <= cap_ay_ff;
                  prev_az_ff   <= cap_az_ff;
                  prev_norm_ff <= cap_rep_ff ? norm_avg : norm_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bias_x       = rsp_bx_ff;
   assign rsp_bias_y       = rsp_by_ff;
   assign rsp_bias_z       = rsp_bz_ff;
   assign rsp_accel_gain   = rsp_gain_ff;
   assign rsp_gain_updated = rsp_upd_ff;

`ifndef ASSERT_OFF
   a_idle_div_free : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_busy)
      else $error("divider busy while idle");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      (gyro_fill_ff <= FILL_MAX) && (gain_fill_ff <= FILL_MAX))
      else $error("window fill beyond depth");

   a_sweep_nonempty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GACC) |-> (gyro_fill_ff != '0))
      else $error("gyro sweep over empty window");

   a_gain_flag : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KDIV && div_done) |=> updated_ff)
      else $error("gain recomputed without flag");
`endif

endmodule
